FILE: rtl/core/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is held.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: rtl/core/ffoa_pkg.sv
`timescale 1ns / 1ps

package ffoa_pkg;

  // Pool size register
  localparam int PoolBits = 17;
  localparam logic [PoolBits-1:0] PoolReset = 17'h10000;

  // Default geometry
  localparam int FreeSlotsDefault  = 16;
  localparam int OffsetBitsDefault = 16;

  // Request codes
  localparam logic CmdAlloc = 1'b0;
  localparam logic CmdFree  = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    StatusOk        = 2'd0,
    StatusExhausted = 2'd1,
    StatusListFull  = 2'd2
  } status_e;

endpackage

FILE: rtl/core/ffoa_ram.sv
`timescale 1ns / 1ps

module ffoa_ram #(
  parameter int  WIDTH = 32,
  parameter int  DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AW-1:0]       waddr_i,
  input  logic [WIDTH-1:0]    wdata_i,
  input  logic                re_i,
  input  logic [AW-1:0]       raddr_i,
  output logic [WIDTH-1:0]    rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/first_fit_offset_allocator.sv
`timescale 1ns / 1ps

// First-fit offset allocator. Allocate requests take the first free-list entry,
// in list order, whose length covers the request, else bump-allocate from the
// top pointer up to min(pool size, offset space). Free requests extend the first
// entry ending at the freed offset, else append a new entry. The free list lives
// in a single-port-read, single-port-write RAM that is walked one entry a cycle;
// a hit ends the walk early, and an allocate that empties an entry then shifts
// every later entry down one place. A stall on the result side holds the item
// until the output register is free. One item is processed at a time; the result
// sits in an output register, so the next item may be accepted while it waits.
module first_fit_offset_allocator #(
  parameter int FREE_SLOTS  = ffoa_pkg::FreeSlotsDefault,
  parameter int OFFSET_BITS = ffoa_pkg::OffsetBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ffoa_pkg::PoolBits-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          command_i,
  input  logic [OFFSET_BITS-1:0]        offset_i,
  input  logic [OFFSET_BITS-1:0]        size_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [OFFSET_BITS-1:0]        granted_offset_o,
  output logic [1:0]                    status_o,
  output logic                          from_free_list_o
);

  localparam int OB = OFFSET_BITS;
  localparam int IW = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
  localparam int CW = $clog2(FREE_SLOTS + 2);
  localparam int EW = 2 * OB;
  localparam int SW = ((OB + 1 > ffoa_pkg::PoolBits) ? OB + 1 : ffoa_pkg::PoolBits) + 1;

  typedef enum logic [1:0] {StIdle, StScan, StShift, StDone} state_e;

  state_e                       state_q, state_d;
  logic [ffoa_pkg::PoolBits-1:0] pool_q, pool_d;
  logic [CW-1:0]                count_q, count_d;
  logic [OB:0]                  bump_q, bump_d;
  logic                         cmd_q, cmd_d;
  logic [OB-1:0]                ofs_q, ofs_d;
  logic [OB-1:0]                size_q, size_d;
  logic [CW-1:0]                rd_idx_q, rd_idx_d;
  logic                         ev_valid_q, ev_valid_d;
  logic [IW-1:0]                sh_wr_q, sh_wr_d;
  logic [OB-1:0]                res_granted_q, res_granted_d;
  ffoa_pkg::status_e            res_status_q, res_status_d;
  logic                         res_ffl_q, res_ffl_d;
  logic                         out_valid_q, out_valid_d;
  logic [OB-1:0]                out_granted_q, out_granted_d;
  ffoa_pkg::status_e            out_status_q, out_status_d;
  logic                         out_ffl_q, out_ffl_d;

  logic          ram_we, ram_re;
  logic [IW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_wdata, ram_rdata;

  logic [OB-1:0] rd_start, rd_len;
  logic [CW-1:0] hit_idx;
  logic          scan_re, alloc_fit, free_adj, hit, list_full, exhausted;
  logic [OB:0]   end_sum, ext_sum;
  logic [OB-1:0] ext_len, adv_start, shr_len;
  logic [SW-1:0] pool_ext, space, limit, bump_end;

  ffoa_ram #(
    .WIDTH(EW),
    .DEPTH(FREE_SLOTS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Entry fields and per-entry tests
  assign rd_start  = ram_rdata[EW-1:OB];
  assign rd_len    = ram_rdata[OB-1:0];
  assign hit_idx   = rd_idx_q - CW'(1);
  assign scan_re   = rd_idx_q < count_q;
  assign alloc_fit = rd_len >= size_q;
  assign end_sum   = {1'b0, rd_start} + {1'b0, rd_len};
  assign free_adj  = end_sum == {1'b0, ofs_q};
  assign ext_sum   = {1'b0, rd_len} + {1'b0, size_q};
  assign ext_len   = ext_sum[OB] ? {OB{1'b1}} : ext_sum[OB-1:0];
  assign adv_start = rd_start + size_q;
  assign shr_len   = rd_len - size_q;
  assign hit       = ev_valid_q && ((cmd_q == ffoa_pkg::CmdAlloc) ? alloc_fit : free_adj);
  assign list_full = count_q == CW'(FREE_SLOTS);

  // Bump limit: min(pool size, offset space)
  assign pool_ext  = SW'(pool_q);
  assign space     = SW'(1) << OB;
  assign limit     = (pool_ext < space) ? pool_ext : space;
  assign bump_end  = SW'(bump_q) + SW'(size_q);
  assign exhausted = bump_q[OB] || (bump_end > limit);

  always_comb begin
    state_d       = state_q;
    pool_d        = pool_q;
    count_d       = count_q;
    bump_d        = bump_q;
    cmd_d         = cmd_q;
    ofs_d         = ofs_q;
    size_d        = size_q;
    rd_idx_d      = rd_idx_q;
    ev_valid_d    = ev_valid_q;
    sh_wr_d       = sh_wr_q;
    res_granted_d = res_granted_q;
    res_status_d  = res_status_q;
    res_ffl_d     = res_ffl_q;
    out_granted_d = out_granted_q;
    out_status_d  = out_status_q;
    out_ffl_d     = out_ffl_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    in_ready_o    = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = hit_idx[IW-1:0];
    ram_wdata     = ram_rdata;
    ram_re        = 1'b0;
    ram_raddr     = rd_idx_q[IW-1:0];

    // Pool size register
    if (cfg_we_i) begin
      pool_d = cfg_wdata_i;
    end

    unique case (state_q)
      StIdle: begin
        // Take the item and start the list walk at entry 0
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_d         = command_i;
          ofs_d         = offset_i;
          size_d        = size_i;
          rd_idx_d      = '0;
          ev_valid_d    = 1'b0;
          res_granted_d = '0;
          res_status_d  = ffoa_pkg::StatusOk;
          res_ffl_d     = 1'b0;
          state_d       = StScan;
        end
      end

      StScan: begin
        // Issue the next read, evaluate the one that returned
        ram_re     = scan_re;
        rd_idx_d   = rd_idx_q + CW'(1);
        ev_valid_d = scan_re;
        if (hit) begin
          if (cmd_q == ffoa_pkg::CmdAlloc) begin
            res_granted_d = rd_start;
            res_ffl_d     = 1'b1;
            if (shr_len != '0) begin
              ram_we    = 1'b1;
              ram_wdata = {adv_start, shr_len};
              state_d   = StDone;
            end else begin
              sh_wr_d = hit_idx[IW-1:0];
              state_d = StShift;
            end
          end else begin
            ram_we    = 1'b1;
            ram_wdata = {rd_start, ext_len};
            state_d   = StDone;
          end
        end else if (!ev_valid_q && !scan_re) begin
          // No entry matched
          if (cmd_q == ffoa_pkg::CmdAlloc) begin
            if (exhausted) begin
              res_status_d = ffoa_pkg::StatusExhausted;
            end else begin
              res_granted_d = bump_q[OB-1:0];
              bump_d        = bump_end[OB:0];
            end
          end else begin
            if (list_full) begin
              res_status_d = ffoa_pkg::StatusListFull;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = count_q[IW-1:0];
              ram_wdata = {ofs_q, size_q};
              count_d   = count_q + CW'(1);
            end
          end
          state_d = StDone;
        end
      end

      StShift: begin
        // Move each later entry down one place
        ram_re     = scan_re;
        rd_idx_d   = rd_idx_q + CW'(1);
        ev_valid_d = scan_re;
        if (ev_valid_q) begin
          ram_we    = 1'b1;
          ram_waddr = sh_wr_q;
          sh_wr_d   = sh_wr_q + IW'(1);
        end else if (!scan_re) begin
          count_d = count_q - CW'(1);
          state_d = StDone;
        end
      end

      StDone: begin
        // Hand the result to the output register once it is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d   = 1'b1;
          out_granted_d = res_granted_q;
          out_status_d  = res_status_q;
          out_ffl_d     = res_ffl_q;
          state_d       = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      pool_q        <= ffoa_pkg::PoolReset;
      count_q       <= '0;
      bump_q        <= '0;
      cmd_q         <= ffoa_pkg::CmdAlloc;
      ofs_q         <= '0;
      size_q        <= '0;
      rd_idx_q      <= '0;
      ev_valid_q    <= 1'b0;
      sh_wr_q       <= '0;
      res_granted_q <= '0;
      res_status_q  <= ffoa_pkg::StatusOk;
      res_ffl_q     <= 1'b0;
      out_valid_q   <= 1'b0;
      out_granted_q <= '0;
      out_status_q  <= ffoa_pkg::StatusOk;
      out_ffl_q     <= 1'b0;
    end else begin
      state_q       <= state_d;
      pool_q        <= pool_d;
      count_q       <= count_d;
      bump_q        <= bump_d;
      cmd_q         <= cmd_d;
      ofs_q         <= ofs_d;
      size_q        <= size_d;
      rd_idx_q      <= rd_idx_d;
      ev_valid_q    <= ev_valid_d;
      sh_wr_q       <= sh_wr_d;
      res_granted_q <= res_granted_d;
      res_status_q  <= res_status_d;
      res_ffl_q     <= res_ffl_d;
      out_valid_q   <= out_valid_d;
      out_granted_q <= out_granted_d;
      out_status_q  <= out_status_d;
      out_ffl_q     <= out_ffl_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign granted_offset_o = out_granted_q;
  assign status_o         = out_status_q;
  assign from_free_list_o = out_ffl_q;

endmodule

FILE: rtl/core/ffoa_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ffoa_checker #(
  parameter int OFFSET_BITS = ffoa_pkg::OffsetBitsDefault
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_o,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic [OFFSET_BITS-1:0] granted_offset_o,
  input logic [1:0]             status_o,
  input logic                   from_free_list_o
);

  // A waiting result holds its payload
  `ASSERT_CLK(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(granted_offset_o) && $stable(status_o) && $stable(from_free_list_o), "result changed while stalled")

  // A failed request grants nothing
  `ASSERT_CLK(a_err_zero, out_valid_o && status_o != ffoa_pkg::StatusOk |-> granted_offset_o == '0 && !from_free_list_o, "error result carries a grant")

  // A free-list reuse is always a success
  `ASSERT_CLK(a_reuse_ok, out_valid_o && from_free_list_o |-> status_o == ffoa_pkg::StatusOk, "reuse flagged on a failed request")

  // One item at a time: busy right after an accept
  `ASSERT_CLK(a_busy, in_valid_i && in_ready_o |=> !in_ready_o, "accepted an item while busy")

endmodule

bind first_fit_offset_allocator ffoa_checker #(
  .OFFSET_BITS(OFFSET_BITS)
) u_ffoa_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .granted_offset_o(granted_offset_o),
  .status_o        (status_o),
  .from_free_list_o(from_free_list_o)
);
